FILE: hw/rtl/plcpr_pkg.sv
`default_nettype none
package plcpr_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 34;
    localparam int MAG_W   = 33;
    localparam int LIM_W   = 16;

    localparam int ANG_W = 20;
    localparam logic signed [ANG_W-1:0] ANG_PI  = 20'sd205887;
    localparam logic signed [ANG_W+1:0] ANG_2PI = 22'sd411775;

    localparam int CORDIC_STEPS = 17;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int TAB_W        = 16;
    localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        16'd51472, 16'd30385, 16'd16055, 16'd8150, 16'd4091, 16'd2047,
        16'd1024,  16'd512,   16'd256,   16'd128,  16'd64,   16'd32,
        16'd16,    16'd8,     16'd4,     16'd2,    16'd1
    };

    localparam int MUL_A_W = 50;
    localparam int DIG_W   = 16;
    localparam int MUL_B_W = 80;
    localparam int NDIG_W  = 3;
    localparam int ACC_W   = 104;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
        logic [NDIG_W-1:0]  ndig;
        logic               neg;
        logic               clr;
    } t_mul_req;

    function automatic logic [MAG_W-1:0] f_mag(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] m;
        m = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return m[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/plcpr_cordic.sv
`default_nettype none
module plcpr_cordic (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [plcpr_pkg::DIFF_W-1:0]  i_x,
    input  wire logic signed [plcpr_pkg::DIFF_W-1:0]  i_y,
    output logic signed [plcpr_pkg::ANG_W-1:0]        o_angle,
    output logic                                      o_done
);
    import plcpr_pkg::*;

    localparam int VW        = 46;
    localparam int NORM_BIT  = 40;
    localparam int COARSE_BIT = 32;
    localparam int COARSE_SH = 8;

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} t_cstate;

    t_cstate                 r_state;
    logic signed [VW-1:0]    r_x;
    logic signed [VW-1:0]    r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [STEP_W-1:0]       r_i;
    logic                    r_done;

    logic signed [VW-1:0]    w_xe;
    logic signed [VW-1:0]    w_ye;
    logic signed [VW-1:0]    w_ay;
    logic [VW-1:0]           w_mx;
    logic signed [VW-1:0]    w_xs;
    logic signed [VW-1:0]    w_ys;
    logic signed [ANG_W-1:0] w_t;

    always_comb begin
        w_xe = VW'(i_x);
        w_ye = VW'(i_y);
        w_ay = r_y[VW-1] ? -r_y : r_y;
        w_mx = (r_x > w_ay) ? r_x : w_ay;
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
        w_t  = signed'({{(ANG_W-TAB_W){1'b0}}, ATAN_TAB[r_i]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        // left half plane: rotate by pi first
                        if (i_x[DIFF_W-1]) begin
                            r_x <= -w_xe;
                            r_y <= -w_ye;
                            r_z <= i_y[DIFF_W-1] ? -ANG_PI : ANG_PI;
                        end else begin
                            r_x <= w_xe;
                            r_y <= w_ye;
                            r_z <= '0;
                        end
                        r_state <= C_NORM;
                    end
                end
                C_NORM: begin
                    if (w_mx[VW-1:NORM_BIT] != '0) begin
                        r_i     <= '0;
                        r_state <= C_ITER;
                    end else if (w_mx[VW-1:COARSE_BIT] == '0) begin
                        r_x <= r_x <<< COARSE_SH;
                        r_y <= r_y <<< COARSE_SH;
                    end else begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end
                end
                C_ITER: begin
                    if (!r_y[VW-1]) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_t;
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_t;
                    end
                    if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_angle = r_z;
    assign o_done  = r_done;

endmodule
`default_nettype wire

FILE: hw/rtl/plcpr_mul.sv
`default_nettype none
module plcpr_mul (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire plcpr_pkg::t_mul_req                 i_req,
    output logic signed [plcpr_pkg::ACC_W-1:0]       o_acc,
    output logic                                     o_done
);
    import plcpr_pkg::*;

    localparam int PROD_W = MUL_A_W + DIG_W;
    localparam int SH_W   = $clog2(MUL_B_W / DIG_W);

    logic                    r_busy;
    logic                    r_pvalid;
    logic                    r_pneg;
    logic                    r_neg;
    logic                    r_done;
    logic [MUL_A_W-1:0]      r_a;
    logic [MUL_B_W-1:0]      r_b;
    logic [NDIG_W-1:0]       r_left;
    logic [SH_W-1:0]         r_dig;
    logic [SH_W-1:0]         r_psh;
    logic [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic [ACC_W-1:0]        w_ext;
    logic [ACC_W-1:0]        w_term;

    assign w_ext  = ACC_W'(r_prod);
    assign w_term = w_ext << {r_psh, {$clog2(DIG_W){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_pvalid) begin
                r_acc <= r_pneg ? r_acc - signed'(w_term) : r_acc + signed'(w_term);
            end
            if (i_start && !r_busy) begin
                r_a      <= i_req.a;
                r_b      <= i_req.b;
                r_left   <= i_req.ndig;
                r_neg    <= i_req.neg;
                r_dig    <= '0;
                r_pvalid <= 1'b0;
                r_busy   <= 1'b1;
                if (i_req.clr) begin
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                if (r_left != '0) begin
                    // one 16-bit digit of b per beat, lsb first
                    r_prod   <= PROD_W'(r_a) * PROD_W'(r_b[DIG_W-1:0]);
                    r_psh    <= r_dig;
                    r_pneg   <= r_neg;
                    r_dig    <= r_dig + 1'b1;
                    r_left   <= r_left - 1'b1;
                    r_b      <= r_b >> DIG_W;
                    r_pvalid <= 1'b1;
                end else begin
                    r_pvalid <= 1'b0;
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: hw/rtl/polyline_collinear_point_remover.sv
`default_nettype none
// First point of a path goes via S_OUT_C to o_out_valid; the second is held and not output unless
// it ends the path. Later points are dropped from S_CHK when a leg has zero length; otherwise the
// time is set by two normalize-then-rotate passes of the shared CORDIC stage and up to seven
// digit-serial 50x16 multiplies. One point in flight; input stalls meanwhile.
// One output register: the next point is taken while a kept point waits on i_out_stall.
// Reset: synchronous, active low; clears path state, limits load 256 and 114.
module polyline_collinear_point_remover (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [plcpr_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [plcpr_pkg::COORD_W-1:0] i_point_y,
    input  wire logic signed [plcpr_pkg::COORD_W-1:0] i_point_z,
    input  wire logic                                 i_path_end,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [plcpr_pkg::COORD_W-1:0]      o_kept_x,
    output logic signed [plcpr_pkg::COORD_W-1:0]      o_kept_y,
    output logic signed [plcpr_pkg::COORD_W-1:0]      o_kept_z,
    output logic                                      o_kept_last,
    input  wire logic                                 i_cfg_we,
    input  wire logic                                 i_cfg_index,
    input  wire logic [plcpr_pkg::LIM_W-1:0]          i_cfg_data
);
    import plcpr_pkg::*;

    localparam logic CFG_SEP  = 1'b0;
    localparam logic CFG_TURN = 1'b1;

    localparam logic [LIM_W-1:0] SEP_RST  = 16'd256;
    localparam logic [LIM_W-1:0] TURN_RST = 16'd114;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    localparam int TW     = ANG_W + 2;
    localparam int LIM2_W = 2 * LIM_W;
    localparam int L3_W   = 2 * MAG_W + 1;
    localparam int TMP_W  = 2 * MUL_A_W;

    localparam logic [NDIG_W-1:0] NDIG_LIM = NDIG_W'((LIM_W + DIG_W - 1) / DIG_W);
    localparam logic [NDIG_W-1:0] NDIG_Q   = NDIG_W'((MAG_W + DIG_W - 1) / DIG_W);
    localparam logic [NDIG_W-1:0] NDIG_CC  = NDIG_W'((MUL_A_W + DIG_W - 1) / DIG_W);
    localparam logic [NDIG_W-1:0] NDIG_RHS = NDIG_W'((L3_W + DIG_W - 1) / DIG_W);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_ANG1, S_ANG2, S_TURN, S_MGO, S_MWAIT, S_DEC, S_OUT_P, S_UPD, S_OUT_C
    } t_state;

    typedef enum logic [3:0] {
        M_LIM2, M_Q1XX, M_Q1YY, M_Q3XX, M_Q3YY, M_RHS, M_CR1, M_CR2, M_CC
    } t_mop;

    t_state                    r_state;
    t_mop                      r_mop;
    logic [1:0]                r_seen;
    logic [LIM_W-1:0]          r_sep_lim;
    logic [LIM_W-1:0]          r_turn_lim;
    logic signed [COORD_W-1:0] r_ax;
    logic signed [COORD_W-1:0] r_ay;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [COORD_W-1:0] r_pz;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic signed [COORD_W-1:0] r_cz;
    logic                      r_cend;
    logic signed [DIFF_W-1:0]  r_q1x;
    logic signed [DIFF_W-1:0]  r_q1y;
    logic signed [DIFF_W-1:0]  r_q2x;
    logic signed [DIFF_W-1:0]  r_q2y;
    logic signed [DIFF_W-1:0]  r_q3x;
    logic signed [DIFF_W-1:0]  r_q3y;
    logic signed [ANG_W-1:0]   r_z1;
    logic signed [ANG_W-1:0]   r_z2;
    logic [LIM2_W-1:0]         r_lim2;
    logic [TMP_W-1:0]          r_tmp;
    logic [MUL_A_W-1:0]        r_cross;
    logic                      r_drop;
    logic                      r_ov;
    logic signed [COORD_W-1:0] r_kx;
    logic signed [COORD_W-1:0] r_ky;
    logic signed [COORD_W-1:0] r_kz;
    logic                      r_kl;

    logic                      w_accept;
    logic                      w_slot;
    logic                      w_q1zero;
    logic                      w_q2zero;
    logic                      w_q3zero;
    logic signed [TW-1:0]      w_turn;
    logic signed [TW-1:0]      w_t1;
    logic signed [TW-1:0]      w_t2;
    logic [TW-1:0]             w_tabs;
    logic                      w_turn_ok;
    logic                      w_cor_start;
    logic signed [DIFF_W-1:0]  w_cor_x;
    logic signed [DIFF_W-1:0]  w_cor_y;
    logic signed [ANG_W-1:0]   w_cor_ang;
    logic                      w_cor_done;
    logic                      w_mul_start;
    t_mul_req                  w_req;
    logic signed [ACC_W-1:0]   w_acc;
    logic [ACC_W-1:0]          w_acc_u;
    logic [ACC_W-1:0]          w_acc_abs;
    logic                      w_cross_big;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_slot     = !r_ov || !i_out_stall;

    assign w_q1zero = (r_q1x == '0) && (r_q1y == '0);
    assign w_q2zero = (r_q2x == '0) && (r_q2y == '0);
    assign w_q3zero = (r_q3x == '0) && (r_q3y == '0);

    always_comb begin
        w_turn    = TW'(r_z1) - TW'(r_z2);
        w_t1      = (w_turn < -TW'(ANG_PI)) ? w_turn + ANG_2PI : w_turn;
        w_t2      = (w_t1 > TW'(ANG_PI)) ? w_t1 - ANG_2PI : w_t1;
        w_tabs    = w_t2[TW-1] ? TW'(-w_t2) : TW'(w_t2);
        w_turn_ok = w_tabs < TW'(r_turn_lim);
    end

    assign w_cor_start = ((r_state == S_CHK) && !w_q1zero && !w_q2zero)
                       || ((r_state == S_ANG1) && w_cor_done);
    assign w_cor_x = (r_state == S_CHK) ? r_q1x : r_q2x;
    assign w_cor_y = (r_state == S_CHK) ? r_q1y : r_q2y;

    plcpr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_x     (w_cor_x),
        .i_y     (w_cor_y),
        .o_angle (w_cor_ang),
        .o_done  (w_cor_done)
    );

    always_comb begin
        w_req = '0;
        unique case (r_mop)
            M_LIM2: begin
                w_req.a    = MUL_A_W'(r_sep_lim);
                w_req.b    = MUL_B_W'(r_sep_lim);
                w_req.ndig = NDIG_LIM;
                w_req.clr  = 1'b1;
            end
            M_Q1XX: begin
                w_req.a    = MUL_A_W'(f_mag(r_q1x));
                w_req.b    = MUL_B_W'(f_mag(r_q1x));
                w_req.ndig = NDIG_Q;
                w_req.clr  = 1'b1;
            end
            M_Q1YY: begin
                w_req.a    = MUL_A_W'(f_mag(r_q1y));
                w_req.b    = MUL_B_W'(f_mag(r_q1y));
                w_req.ndig = NDIG_Q;
            end
            M_Q3XX: begin
                w_req.a    = MUL_A_W'(f_mag(r_q3x));
                w_req.b    = MUL_B_W'(f_mag(r_q3x));
                w_req.ndig = NDIG_Q;
                w_req.clr  = 1'b1;
            end
            M_Q3YY: begin
                w_req.a    = MUL_A_W'(f_mag(r_q3y));
                w_req.b    = MUL_B_W'(f_mag(r_q3y));
                w_req.ndig = NDIG_Q;
            end
            M_RHS: begin
                w_req.a    = MUL_A_W'(r_lim2);
                w_req.b    = MUL_B_W'(r_tmp[L3_W-1:0]);
                w_req.ndig = NDIG_RHS;
                w_req.clr  = 1'b1;
            end
            M_CR1: begin
                w_req.a    = MUL_A_W'(f_mag(r_q1x));
                w_req.b    = MUL_B_W'(f_mag(r_q3y));
                w_req.ndig = NDIG_Q;
                w_req.neg  = r_q1x[DIFF_W-1] ^ r_q3y[DIFF_W-1];
                w_req.clr  = 1'b1;
            end
            M_CR2: begin
                w_req.a    = MUL_A_W'(f_mag(r_q3x));
                w_req.b    = MUL_B_W'(f_mag(r_q1y));
                w_req.ndig = NDIG_Q;
                w_req.neg  = !(r_q3x[DIFF_W-1] ^ r_q1y[DIFF_W-1]);
            end
            M_CC: begin
                w_req.a    = r_cross;
                w_req.b    = MUL_B_W'(r_cross);
                w_req.ndig = NDIG_CC;
                w_req.clr  = 1'b1;
            end
            default: w_req = '0;
        endcase
    end

    assign w_mul_start = (r_state == S_MGO);

    plcpr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_req   (w_req),
        .o_acc   (w_acc),
        .o_done  (w_mul_done)
    );

    logic w_mul_done;

    assign w_acc_u     = w_acc;
    assign w_acc_abs   = w_acc[ACC_W-1] ? ACC_W'(-w_acc) : ACC_W'(w_acc);
    assign w_cross_big = (w_acc_abs[ACC_W-1:MUL_A_W] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mop      <= M_LIM2;
            r_seen     <= SEEN_NONE;
            r_sep_lim  <= SEP_RST;
            r_turn_lim <= TURN_RST;
            r_ov       <= 1'b0;
            r_ax       <= '0;
            r_ay       <= '0;
            r_px       <= '0;
            r_py       <= '0;
            r_pz       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEP:  r_sep_lim  <= i_cfg_data;
                    CFG_TURN: r_turn_lim <= i_cfg_data;
                    default:  ;
                endcase
            end

            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cx   <= i_point_x;
                        r_cy   <= i_point_y;
                        r_cz   <= i_point_z;
                        r_cend <= i_path_end;
                        if (r_seen == SEEN_NONE) begin
                            r_ax    <= i_point_x;
                            r_ay    <= i_point_y;
                            r_seen  <= i_path_end ? SEEN_NONE : SEEN_ONE;
                            r_state <= S_OUT_C;
                        end else if (r_seen == SEEN_ONE) begin
                            r_px <= i_point_x;
                            r_py <= i_point_y;
                            r_pz <= i_point_z;
                            if (i_path_end) begin
                                r_seen  <= SEEN_NONE;
                                r_state <= S_OUT_C;
                            end else begin
                                r_seen <= SEEN_TWO;
                            end
                        end else begin
                            r_q1x   <= DIFF_W'(r_px) - DIFF_W'(r_ax);
                            r_q1y   <= DIFF_W'(r_py) - DIFF_W'(r_ay);
                            r_q2x   <= DIFF_W'(i_point_x) - DIFF_W'(r_px);
                            r_q2y   <= DIFF_W'(i_point_y) - DIFF_W'(r_py);
                            r_q3x   <= DIFF_W'(i_point_x) - DIFF_W'(r_ax);
                            r_q3y   <= DIFF_W'(i_point_y) - DIFF_W'(r_ay);
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (w_q1zero || w_q2zero) begin
                        r_drop  <= 1'b1;
                        r_state <= S_DEC;
                    end else begin
                        r_state <= S_ANG1;
                    end
                end
                S_ANG1: begin
                    if (w_cor_done) begin
                        r_z1    <= w_cor_ang;
                        r_state <= S_ANG2;
                    end
                end
                S_ANG2: begin
                    if (w_cor_done) begin
                        r_z2    <= w_cor_ang;
                        r_state <= S_TURN;
                    end
                end
                S_TURN: begin
                    if (!w_turn_ok) begin
                        r_drop  <= 1'b0;
                        r_state <= S_DEC;
                    end else begin
                        r_mop   <= M_LIM2;
                        r_state <= S_MGO;
                    end
                end
                S_MGO: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (w_mul_done) begin
                        r_state <= S_MGO;
                        unique case (r_mop)
                            M_LIM2: begin
                                r_lim2 <= w_acc_u[LIM2_W-1:0];
                                r_mop  <= w_q3zero ? M_Q1XX : M_Q3XX;
                            end
                            M_Q1XX: r_mop <= M_Q1YY;
                            M_Q1YY: begin
                                // closing leg is zero: first leg length against the limit
                                r_drop  <= w_acc_u < ACC_W'(r_lim2);
                                r_state <= S_DEC;
                            end
                            M_Q3XX: r_mop <= M_Q3YY;
                            M_Q3YY: begin
                                r_tmp <= w_acc_u[TMP_W-1:0];
                                r_mop <= M_RHS;
                            end
                            M_RHS: begin
                                r_tmp <= w_acc_u[TMP_W-1:0];
                                r_mop <= M_CR1;
                            end
                            M_CR1: r_mop <= M_CR2;
                            M_CR2: begin
                                if (w_cross_big) begin
                                    r_drop  <= 1'b0;
                                    r_state <= S_DEC;
                                end else begin
                                    r_cross <= w_acc_abs[MUL_A_W-1:0];
                                    r_mop   <= M_CC;
                                end
                            end
                            M_CC: begin
                                r_drop  <= w_acc_u[TMP_W-1:0] < r_tmp;
                                r_state <= S_DEC;
                            end
                            default: begin
                                r_drop  <= 1'b0;
                                r_state <= S_DEC;
                            end
                        endcase
                    end
                end
                S_DEC: r_state <= r_drop ? S_UPD : S_OUT_P;
                S_OUT_P: begin
                    if (w_slot) begin
                        r_ov    <= 1'b1;
                        r_kx    <= r_px;
                        r_ky    <= r_py;
                        r_kz    <= r_pz;
                        r_kl    <= 1'b0;
                        r_ax    <= r_px;
                        r_ay    <= r_py;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_px <= r_cx;
                    r_py <= r_cy;
                    r_pz <= r_cz;
                    if (r_cend) begin
                        r_seen  <= SEEN_NONE;
                        r_state <= S_OUT_C;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT_C: begin
                    if (w_slot) begin
                        r_ov    <= 1'b1;
                        r_kx    <= r_cx;
                        r_ky    <= r_cy;
                        r_kz    <= r_cz;
                        r_kl    <= r_cend;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_kept_x    = r_kx;
    assign o_kept_y    = r_ky;
    assign o_kept_z    = r_kz;
    assign o_kept_last = r_kl;

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_TWO)
        else $error("point count out of range");

    a_cordic_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cor_done |-> (r_state == S_ANG1 || r_state == S_ANG2))
        else $error("angle result with no angle request pending");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MWAIT))
        else $error("product result with no multiply pending");

endmodule
`default_nettype wire
